FILE: src/wcws_pkg.sv
// wcws_pkg: shared constants, codes and controller/datapath interface types
// for the wait counter with waiter slots. No dependencies.
`default_nettype none

package wcws_pkg;

  localparam int WAIT_SLOTS = 8;
  localparam int SLOT_W     = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;

  localparam logic [1:0] MODE_INC  = 2'd0;
  localparam logic [1:0] MODE_DEC  = 2'd1;
  localparam logic [1:0] MODE_WAIT = 2'd2;

  localparam logic [2:0] KIND_RELEASE   = 3'd0;
  localparam logic [2:0] KIND_ACK       = 3'd1;
  localparam logic [2:0] KIND_SATISFIED = 3'd2;
  localparam logic [2:0] KIND_PARKED    = 3'd3;
  localparam logic [2:0] KIND_FULL      = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACK,
    ST_WAITER
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;
    logic       emit;
    logic [2:0] kind;
    logic       clear_busy;
    logic       park;
    logic       idx_inc;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic hit;
    logic out_free;
    logic idx_last;
    logic free_found;
    logic tgt_eq;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: src/wcws_dp.sv
// wcws_dp: datapath of the wait counter - counter, waiter slot table,
// scan index and result register. Depends on wcws_pkg.
`default_nettype none

module wcws_dp (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire wcws_pkg::dp_cmd_t       cmd,
  output wcws_pkg::dp_sts_t            sts,
  input  wire logic [1:0]              in_mode,
  input  wire logic [31:0]             in_amount,
  input  wire logic [15:0]             in_fiber_id,
  input  wire logic [31:0]             in_target_value,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [2:0]                   out_kind,
  output logic [31:0]                  out_count_value,
  output logic [15:0]                  out_released_fiber,
  output logic                         out_last
);

  logic [31:0] count_r;
  logic [31:0] prev_r;
  logic [15:0] fiber_r;
  logic [31:0] target_r;
  logic [wcws_pkg::WAIT_SLOTS-1:0] busy_r;
  logic [15:0] slot_fiber_r  [wcws_pkg::WAIT_SLOTS];
  logic [31:0] slot_target_r [wcws_pkg::WAIT_SLOTS];
  logic [wcws_pkg::SLOT_W-1:0] idx_r;

  logic        out_valid_r;
  logic [2:0]  out_kind_r;
  logic [31:0] out_count_r;
  logic [15:0] out_fiber_r;
  logic        out_last_r;

  logic [wcws_pkg::SLOT_W-1:0] free_idx;
  logic                        free_found;
  logic                        out_free;

  // lowest free slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = wcws_pkg::WAIT_SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_idx   = wcws_pkg::SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;

  assign sts.hit        = busy_r[idx_r] && (slot_target_r[idx_r] == count_r);
  assign sts.out_free   = out_free;
  assign sts.idx_last   = (idx_r == wcws_pkg::SLOT_W'(wcws_pkg::WAIT_SLOTS - 1));
  assign sts.free_found = free_found;
  assign sts.tgt_eq     = (target_r == count_r);

  // item capture and counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      if (cmd.load) begin
        idx_r <= '0;
        if (in_mode == wcws_pkg::MODE_INC) begin
          count_r <= count_r + in_amount;
        end else if (in_mode == wcws_pkg::MODE_DEC) begin
          count_r <= count_r - in_amount;
        end
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prev_r   <= count_r;
      fiber_r  <= in_fiber_id;
      target_r <= in_target_value;
    end
  end

  // slot table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else begin
      if (cmd.clear_busy) begin
        busy_r[idx_r] <= 1'b0;
      end
      if (cmd.park) begin
        busy_r[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.park) begin
      slot_fiber_r[free_idx]  <= fiber_r;
      slot_target_r[free_idx] <= target_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r  <= cmd.kind;
      out_count_r <= (cmd.kind == wcws_pkg::KIND_ACK) ? prev_r : count_r;
      out_fiber_r <= (cmd.kind == wcws_pkg::KIND_RELEASE) ? slot_fiber_r[idx_r] : 16'd0;
      out_last_r  <= (cmd.kind != wcws_pkg::KIND_RELEASE);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_count_value    = out_count_r;
  assign out_released_fiber = out_fiber_r;
  assign out_last           = out_last_r;

`ifndef ASSERT_OFF
  a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("result written while the result register is occupied");

  a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_busy |-> (busy_r[idx_r] && cmd.emit && cmd.kind == wcws_pkg::KIND_RELEASE))
    else $error("slot freed without a release transaction");

  a_park_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.park |-> (free_found && cmd.kind == wcws_pkg::KIND_PARKED))
    else $error("waiter parked with no free slot");

  a_park_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.park |=> busy_r[$past(free_idx)])
    else $error("parked slot not marked busy");
`endif

endmodule

`default_nettype wire

FILE: src/wcws_ctrl.sv
// wcws_ctrl: controller state machine sequencing the slot scan, acknowledge
// and waiter placement. Depends on wcws_pkg.
`default_nettype none

module wcws_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_mode,
  output logic                   in_ready,
  input  wire wcws_pkg::dp_sts_t sts,
  output wcws_pkg::dp_cmd_t      cmd
);

  wcws_pkg::state_t state_r;
  wcws_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wcws_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd.load       = 1'b0;
    cmd.emit       = 1'b0;
    cmd.kind       = wcws_pkg::KIND_ACK;
    cmd.clear_busy = 1'b0;
    cmd.park       = 1'b0;
    cmd.idx_inc    = 1'b0;
    case (state_r)
      wcws_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_mode == wcws_pkg::MODE_INC || in_mode == wcws_pkg::MODE_DEC) begin
            state_nxt = wcws_pkg::ST_SCAN;
          end else if (in_mode == wcws_pkg::MODE_WAIT) begin
            state_nxt = wcws_pkg::ST_WAITER;
          end
        end
      end
      wcws_pkg::ST_SCAN: begin
        // a matching slot holds the scan until its release can be written
        if (!sts.hit || sts.out_free) begin
          if (sts.hit) begin
            cmd.emit       = 1'b1;
            cmd.kind       = wcws_pkg::KIND_RELEASE;
            cmd.clear_busy = 1'b1;
          end
          if (sts.idx_last) begin
            state_nxt = wcws_pkg::ST_ACK;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      wcws_pkg::ST_ACK: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = wcws_pkg::KIND_ACK;
          state_nxt = wcws_pkg::ST_IDLE;
        end
      end
      wcws_pkg::ST_WAITER: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = wcws_pkg::ST_IDLE;
          if (!sts.free_found) begin
            cmd.kind = wcws_pkg::KIND_FULL;
          end else if (sts.tgt_eq) begin
            cmd.kind = wcws_pkg::KIND_SATISFIED;
          end else begin
            cmd.kind = wcws_pkg::KIND_PARKED;
            cmd.park = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = wcws_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/wait_counter_with_waiter_slots_unit.sv
// Update item: the accept state, a scan step for each waiter slot (WAIT_SLOTS),
// then the acknowledge state; add-waiter item: the accept and waiter states;
// unused mode: the accept state alone. A full result register stalls the work.
// One item at a time: the controller takes input only in its idle state.
// Synchronous active-low reset: counter zero, every slot free, no result.
`default_nettype none

module wait_counter_with_waiter_slots_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [31:0] in_amount,
  input  wire logic [15:0] in_fiber_id,
  input  wire logic [31:0] in_target_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [31:0]      out_count_value,
  output logic [15:0]      out_released_fiber,
  output logic             out_last
);

  wcws_pkg::dp_cmd_t cmd;
  wcws_pkg::dp_sts_t sts;

  wcws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wcws_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_mode            (in_mode),
    .in_amount          (in_amount),
    .in_fiber_id        (in_fiber_id),
    .in_target_value    (in_target_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_count_value    (out_count_value),
    .out_released_fiber (out_released_fiber),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire

FILE: test/wait_counter_with_waiter_slots_unit_test.sv
// testbench for wait_counter_with_waiter_slots_unit: a scoreboard class predicts each result
// from the accepted transactions and checks the result stream. depends on wcws_pkg and the RTL.
`default_nettype none

module wait_counter_with_waiter_slots_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam int PHASE_ITEMS = 120;
  localparam int HOLD_CYCLES = 400;

  class wait_table_scoreboard;
    typedef struct {
      logic [2:0]  kind;
      logic [31:0] count_value;
      logic [15:0] fiber;
      logic        last;
    } slot_result_t;

    bit [31:0] counter;
    bit        busy[wcws_pkg::WAIT_SLOTS];
    bit [15:0] fiber_tab[wcws_pkg::WAIT_SLOTS];
    bit [31:0] target_tab[wcws_pkg::WAIT_SLOTS];
    slot_result_t results_due[$];
    int errors;

    function new();
      counter = '0;
      errors = 0;
      foreach (busy[i]) begin
        busy[i] = 1'b0;
        fiber_tab[i] = '0;
        target_tab[i] = '0;
      end
    endfunction

    task flag(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void push(logic [2:0] kind, logic [31:0] cv, logic [15:0] fib, logic last);
      slot_result_t r;
      r.kind = kind;
      r.count_value = cv;
      r.fiber = fib;
      r.last = last;
      results_due.push_back(r);
    endfunction

    // counter moves, then matching waiters leave in slot order, ack last
    function void apply_update(bit [31:0] next);
      bit [31:0] prev;
      prev = counter;
      counter = next;
      for (int i = 0; i < wcws_pkg::WAIT_SLOTS; i++) begin
        if (busy[i] && target_tab[i] == next) begin
          busy[i] = 1'b0;
          push(wcws_pkg::KIND_RELEASE, next, fiber_tab[i], 1'b0);
        end
      end
      push(wcws_pkg::KIND_ACK, prev, 16'h0000, 1'b1);
    endfunction

    function void add_waiter(bit [15:0] fib, bit [31:0] tgt);
      for (int i = 0; i < wcws_pkg::WAIT_SLOTS; i++) begin
        if (!busy[i]) begin
          fiber_tab[i] = fib;
          target_tab[i] = tgt;
          if (tgt == counter) begin
            push(wcws_pkg::KIND_SATISFIED, counter, 16'h0000, 1'b1);
          end else begin
            busy[i] = 1'b1;
            push(wcws_pkg::KIND_PARKED, counter, 16'h0000, 1'b1);
          end
          return;
        end
      end
      push(wcws_pkg::KIND_FULL, counter, 16'h0000, 1'b1);
    endfunction

    function void note_input(logic [1:0] mode, logic [31:0] amount, logic [15:0] fib,
                             logic [31:0] tgt);
      case (mode)
        wcws_pkg::MODE_INC:  apply_update(counter + amount);
        wcws_pkg::MODE_DEC:  apply_update(counter - amount);
        wcws_pkg::MODE_WAIT: add_waiter(fib, tgt);
        default: ;
      endcase
    endfunction

    task check_result(logic [2:0] kind, logic [31:0] cv, logic [15:0] fib,
                      logic last);
      slot_result_t r;
      if (results_due.size() == 0) begin
        flag($sformatf("unexpected result kind %0d count %h", kind, cv));
        return;
      end
      r = results_due.pop_front();
      if (kind !== r.kind)
        flag($sformatf("kind %0d, wanted %0d", kind, r.kind));
      if (cv !== r.count_value)
        flag($sformatf("count_value %h, wanted %h", cv, r.count_value));
      if (fib !== r.fiber)
        flag($sformatf("released_fiber %h, wanted %h", fib, r.fiber));
      if (last !== r.last)
        flag($sformatf("last %b, wanted %b", last, r.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic [31:0] in_amount;
  logic [15:0] in_fiber_id;
  logic [31:0] in_target_value;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_kind;
  logic [31:0] out_count_value;
  logic [15:0] out_released_fiber;
  logic        out_last;

  wait_table_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int items_sent;
  int hold_req_cnt;

  wait_counter_with_waiter_slots_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_amount          (in_amount),
    .in_fiber_id        (in_fiber_id),
    .in_target_value    (in_target_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_count_value    (out_count_value),
    .out_released_fiber (out_released_fiber),
    .out_last           (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_input(in_mode, in_amount, in_fiber_id, in_target_value);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_kind, out_count_value, out_released_fiber, out_last);
  end

  // receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int hold_done;
    hold_done = 0;
    forever begin
      @(negedge clk);
      if (hold_req_cnt != hold_done) begin
        hold_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_item(logic [1:0] mode, logic [31:0] amount, logic [15:0] fib,
                           logic [31:0] tgt);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_mode <= mode;
    in_amount <= amount;
    in_fiber_id <= fib;
    in_target_value <= tgt;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (mode != MODE_IGNORED)
      items_sent++;
    @(negedge clk);
  endtask

  task automatic directed_items();
    send_item(wcws_pkg::MODE_INC, 32'h0000_0000, 16'h0000, 32'h0000_0000);
    // already satisfied
    send_item(wcws_pkg::MODE_WAIT, 32'hffff_ffff, 16'hffff, 32'h0000_0000);
    send_item(wcws_pkg::MODE_INC, 32'hffff_ffff, 16'h0000, 32'hffff_ffff);
    send_item(wcws_pkg::MODE_INC, 32'h0000_0001, 16'hffff, 32'h0000_0000);  // wraps to zero
    send_item(wcws_pkg::MODE_DEC, 32'h0000_0001, 16'h0000, 32'hffff_ffff);  // wraps below zero
    send_item(wcws_pkg::MODE_DEC, 32'hffff_ffff, 16'hffff, 32'h0000_0000);
    // every slot waits for the same value, so one update releases all of them
    for (int i = 0; i < wcws_pkg::WAIT_SLOTS; i++)
      send_item(wcws_pkg::MODE_WAIT, 32'h0, 16'hffff - 16'(i) * 16'h1111, 32'h0000_0005);
    send_item(wcws_pkg::MODE_WAIT, 32'h0, 16'ha5a5, 32'h0000_0007);  // table full
    send_item(MODE_IGNORED, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
    send_item(wcws_pkg::MODE_INC, 32'h0000_0005, 16'h0000, 32'h0000_0000);
    send_item(wcws_pkg::MODE_WAIT, 32'h0, 16'h0001, 32'hffff_ffff);
    send_item(wcws_pkg::MODE_WAIT, 32'h0, 16'h0000, 32'h0000_0000);
    send_item(wcws_pkg::MODE_DEC, 32'h0000_0005, 16'h0000, 32'h0000_0000);
    send_item(wcws_pkg::MODE_DEC, 32'h0000_0001, 16'h0000, 32'h0000_0000);
    send_item(wcws_pkg::MODE_INC, 32'h0000_0001, 16'h0000, 32'h0000_0000);
    send_item(MODE_IGNORED, 32'h0, 16'h0, 32'h0);
  endtask

  task automatic random_round();
    int pick;
    int k;
    int d;
    bit up;
    bit [31:0] tgt;
    pick = $urandom_range(99);
    if (pick < 60) begin
      // park a few waiters just ahead of the counter, then walk it across them
      up = 1'($urandom_range(1));
      k = $urandom_range(1, wcws_pkg::WAIT_SLOTS + 1);
      for (int i = 0; i < k; i++) begin
        d = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
        tgt = up ? sb.counter + 32'(d) : sb.counter - 32'(d);
        send_item(wcws_pkg::MODE_WAIT, $urandom, 16'($urandom), tgt);
      end
      k = $urandom_range(2, 6);
      for (int i = 0; i < k; i++)
        send_item(up ? wcws_pkg::MODE_INC : wcws_pkg::MODE_DEC, $urandom_range(1, 2),
                  16'($urandom), $urandom);
    end else if (pick < 75) begin
      // land exactly on a parked waiter, clears stale entries
      for (int i = 0; i < wcws_pkg::WAIT_SLOTS; i++) begin
        if (sb.busy[i]) begin
          send_item(wcws_pkg::MODE_INC, sb.target_tab[i] - sb.counter, 16'($urandom),
                    $urandom);
          break;
        end
      end
      send_item(wcws_pkg::MODE_WAIT, $urandom, 16'($urandom), sb.counter);
    end else if (pick < 90) begin
      k = $urandom_range(2);
      send_item(k[1:0], $urandom, 16'($urandom), $urandom);
    end else if (pick < 95) begin
      send_item(MODE_IGNORED, $urandom, 16'($urandom), $urandom);
    end else begin
      // broken sequence: wait upward, then move away
      send_item(wcws_pkg::MODE_WAIT, $urandom, 16'($urandom), sb.counter + 32'd3);
      send_item(wcws_pkg::MODE_DEC, $urandom_range(1, 3), 16'($urandom), $urandom);
    end
  endtask

  initial begin
    #5_000_000;
    $display("wait_counter_with_waiter_slots_unit_test: done, errors");
    $finish;
  end

  initial begin
    int phase_start;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = wcws_pkg::MODE_INC;
    in_amount = '0;
    in_fiber_id = '0;
    in_target_value = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_sent = 0;
    hold_req_cnt = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_items();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (p == 0)
        hold_req_cnt <= hold_req_cnt + 1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS)
        random_round();
    end

    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (4 * (wcws_pkg::WAIT_SLOTS + 2)) @(posedge clk);
    if (sb.results_due.size() != 0)
      sb.flag($sformatf("%0d results never arrived", sb.results_due.size()));

    if (sb.errors == 0) begin
      $display("wait_counter_with_waiter_slots_unit_test: done, clean");
    end else begin
      $display("wait_counter_with_waiter_slots_unit_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
